### hw/rtl/mdh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdh_pkg: decode stage constants
// Opcodes, function codes, ALU control codes and control bit patterns used by
// the MIPS decode and load-use hazard stage.
// ----------------------------------------------------------------------------
package mdh_pkg;

    localparam int unsigned INSN_W = 32;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned REG_W  = 5;
    localparam int unsigned IMM_W  = 16;
    localparam int unsigned ALU_W  = 3;
    localparam int unsigned CB_W   = 9;
    localparam int unsigned OFS_W  = 18;

    typedef logic [5:0]        opcode_t;
    typedef logic [5:0]        funct_t;
    typedef logic [ALU_W-1:0]  alu_ctl_t;
    typedef logic [CB_W-1:0]   ctl_bits_t;
    typedef logic [REG_W-1:0]  reg_idx_t;

    localparam opcode_t OP_RTYPE = 6'd0;
    localparam opcode_t OP_BEQ   = 6'd4;
    localparam opcode_t OP_ADDI  = 6'd8;
    localparam opcode_t OP_ORI   = 6'd13;
    localparam opcode_t OP_LW    = 6'd35;

    localparam funct_t FN_ADD = 6'd32;
    localparam funct_t FN_SUB = 6'd34;
    localparam funct_t FN_AND = 6'd36;
    localparam funct_t FN_OR  = 6'd37;

    localparam alu_ctl_t ALU_AND = 3'b000;
    localparam alu_ctl_t ALU_OR  = 3'b001;
    localparam alu_ctl_t ALU_ADD = 3'b010;
    localparam alu_ctl_t ALU_SUB = 3'b110;

    localparam ctl_bits_t CB_RTYPE = 9'b110000010;
    localparam ctl_bits_t CB_BEQ   = 9'b001010000;
    localparam ctl_bits_t CB_ADDI  = 9'b000100010;
    localparam ctl_bits_t CB_ORI   = 9'b011100010;
    localparam ctl_bits_t CB_LW    = 9'b000101011;

    localparam int unsigned CB_BRANCH_BIT = 4;

endpackage : mdh_pkg
`default_nettype wire

### hw/rtl/mips_decode_hazard_stage_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mips_decode_hazard_stage_unit: MIPS decode stage with load-use detection
// Splits instruction fields, decodes controls, flags load-use stalls and
// resolves beq with its byte offset.
// ----------------------------------------------------------------------------
// One result per instruction, in the cycle after its transfer. Decode is a
// single pass of logic from the input ports and the three state registers
// (pending load destination, last ALU control, last control bits) into one
// output register; an instruction is taken every cycle as long as the output
// register is empty or being drained, so throughput is one instruction per
// clock. The state registers update at the input transfer, so each
// instruction sees the state left by the one before it. An all-zero word
// returns the state to reset and yields a bubble result.
module mips_decode_hazard_stage_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [mdh_pkg::INSN_W-1:0]         s_instruction,
    input  wire logic signed [mdh_pkg::DATA_W-1:0]  s_rs_value,
    input  wire logic signed [mdh_pkg::DATA_W-1:0]  s_rt_value,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [mdh_pkg::DATA_W-1:0]       m_read_data_one,
    output logic signed [mdh_pkg::DATA_W-1:0]       m_read_data_two,
    output logic [mdh_pkg::REG_W-1:0]               m_source_reg,
    output logic [mdh_pkg::REG_W-1:0]               m_target_reg,
    output logic [mdh_pkg::REG_W-1:0]               m_dest_reg,
    output logic signed [mdh_pkg::IMM_W-1:0]        m_immediate,
    output logic [mdh_pkg::ALU_W-1:0]               m_alu_control,
    output logic [mdh_pkg::CB_W-1:0]                m_control_bits,
    output logic                                    m_stall_res,
    output logic                                    m_branch_taken,
    output logic signed [mdh_pkg::OFS_W-1:0]        m_branch_offset,
    output logic                                    m_bubble
);
    import mdh_pkg::*;

    // decode state
    reg_idx_t  pend_reg,   pend_next;
    alu_ctl_t  alu_reg,    alu_next;
    ctl_bits_t cb_reg,     cb_next;

    // output register
    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] rd1_reg, rd1_next;
    logic signed [DATA_W-1:0] rd2_reg, rd2_next;
    reg_idx_t                 rs_reg, rs_next;
    reg_idx_t                 rt_reg, rt_next;
    reg_idx_t                 rd_reg, rd_next;
    logic signed [IMM_W-1:0]  imm_reg, imm_next;
    alu_ctl_t                 aluo_reg;
    ctl_bits_t                cbo_reg;
    logic                     stall_reg, stall_next;
    logic                     taken_reg, taken_next;
    logic signed [OFS_W-1:0]  ofs_reg, ofs_next;
    logic                     bubble_reg, bubble_next;

    logic     in_xfer;
    opcode_t  op;
    funct_t   fn;
    reg_idx_t f_rs;
    reg_idx_t f_rt;
    logic     pend_live;
    logic     hit_rs;
    logic     hit_rt;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;

    assign op        = s_instruction[31:26];
    assign fn        = s_instruction[5:0];
    assign f_rs      = s_instruction[25:21];
    assign f_rt      = s_instruction[20:16];
    assign pend_live = (pend_reg != '0);
    assign hit_rs    = pend_live && (f_rs == pend_reg);
    assign hit_rt    = pend_live && (f_rt == pend_reg);

    always_comb begin
        pend_next   = pend_reg;
        alu_next    = alu_reg;
        cb_next     = cb_reg;
        stall_next  = 1'b0;
        imm_next    = s_instruction[IMM_W-1:0];
        rd1_next    = s_rs_value;
        rd2_next    = s_rt_value;
        rs_next     = f_rs;
        rt_next     = f_rt;
        rd_next     = s_instruction[15:11];
        bubble_next = 1'b0;
        if (s_instruction == '0) begin
            // clear the stage and drop any pending load
            pend_next   = '0;
            alu_next    = '0;
            cb_next     = '0;
            imm_next    = '0;
            rd1_next    = '0;
            rd2_next    = '0;
            rs_next     = '0;
            rt_next     = '0;
            rd_next     = '0;
            bubble_next = 1'b1;
        end else begin
            unique case (op)
                OP_RTYPE: begin
                    stall_next = hit_rs || hit_rt;
                    cb_next    = CB_RTYPE;
                    pend_next  = '0;
                    imm_next   = '0;
                    unique case (fn)
                        FN_ADD:  alu_next = ALU_ADD;
                        FN_SUB:  alu_next = ALU_SUB;
                        FN_AND:  alu_next = ALU_AND;
                        FN_OR:   alu_next = ALU_OR;
                        default: alu_next = alu_reg;
                    endcase
                end
                OP_BEQ: begin
                    stall_next = hit_rs || hit_rt;
                    alu_next   = ALU_SUB;
                    cb_next    = CB_BEQ;
                    pend_next  = '0;
                end
                OP_ADDI: begin
                    stall_next = hit_rs;
                    alu_next   = ALU_ADD;
                    cb_next    = CB_ADDI;
                    pend_next  = '0;
                end
                OP_ORI: begin
                    stall_next = hit_rs;
                    alu_next   = ALU_OR;
                    cb_next    = CB_ORI;
                    pend_next  = '0;
                end
                OP_LW: begin
                    stall_next = hit_rs;
                    alu_next   = ALU_ADD;
                    cb_next    = CB_LW;
                    pend_next  = f_rt;
                end
                default: begin
                    // unknown opcode: hold controls and pending load
                end
            endcase
        end
    end

    // the kept control bits still decide the branch on an unknown opcode
    assign taken_next = cb_next[CB_BRANCH_BIT] && (s_rs_value == s_rt_value);
    assign ofs_next   = taken_next ? {imm_next, 2'b00} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= '0;
            alu_reg     <= '0;
            cb_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_xfer) begin
                pend_reg    <= pend_next;
                alu_reg     <= alu_next;
                cb_reg      <= cb_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            rd1_reg    <= rd1_next;
            rd2_reg    <= rd2_next;
            rs_reg     <= rs_next;
            rt_reg     <= rt_next;
            rd_reg     <= rd_next;
            imm_reg    <= imm_next;
            aluo_reg   <= alu_next;
            cbo_reg    <= cb_next;
            stall_reg  <= stall_next;
            taken_reg  <= taken_next;
            ofs_reg    <= ofs_next;
            bubble_reg <= bubble_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_read_data_one = rd1_reg;
    assign m_read_data_two = rd2_reg;
    assign m_source_reg    = rs_reg;
    assign m_target_reg    = rt_reg;
    assign m_dest_reg      = rd_reg;
    assign m_immediate     = imm_reg;
    assign m_alu_control   = aluo_reg;
    assign m_control_bits  = cbo_reg;
    assign m_stall_res     = stall_reg;
    assign m_branch_taken  = taken_reg;
    assign m_branch_offset = ofs_reg;
    assign m_bubble        = bubble_reg;

`ifndef ASSERT_OFF
    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_needs_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && stall_next |-> pend_reg != '0)
        else $error("stall raised with no pending load");

    a_bubble_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && bubble_next |=> pend_reg == '0 && alu_reg == '0 && cb_reg == '0)
        else $error("bubble left decode state set");

    a_taken_operands_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_branch_taken |->
            m_read_data_one == m_read_data_two && m_control_bits[CB_BRANCH_BIT])
        else $error("branch taken without equal operands");

    a_offset_only_when_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_branch_taken |-> m_branch_offset == '0)
        else $error("branch offset set on untaken branch");
`endif

endmodule : mips_decode_hazard_stage_unit
`default_nettype wire
